@@ hdl/fbpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_BLOCKS   = 1024;
  localparam int unsigned DEF_OFFSET_WIDTH = 26;

  // Fixed field widths.
  localparam int unsigned OP_W        = 2;
  localparam int unsigned REQ_W       = 32;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned BYTES_W     = 17;
  localparam int unsigned SIZE_W      = REQ_W + ELEM_W;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = BYTES_W;

  // Block size limits and the register values after reset.
  localparam int unsigned ALIGN_BYTES       = 16;
  localparam int unsigned MAX_BLOCK_BYTES   = 65536;
  localparam int unsigned DEF_BLOCK_BYTES   = 16;
  localparam int unsigned DEF_BLOCKS_IN_USE = 1024;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_IN_USE = 8'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_ZALLOC = 2'd1,
    OP_FREE   = 2'd2,
    OP_RESET  = 2'd3
  } fbpa_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_ZERO_SIZE   = 3'd1,
    STAT_TOO_LARGE   = 3'd2,
    STAT_POOL_EMPTY  = 3'd3,
    STAT_BAD_FREE    = 3'd4,
    STAT_NONE_IN_USE = 3'd5
  } fbpa_status_e;

  typedef enum logic [2:0] {
    ST_SWEEP  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_DECIDE = 3'd2,
    ST_DIV    = 3'd3,
    ST_FREE   = 3'd4
  } fbpa_state_e;

endpackage

`default_nettype wire

@@ hdl/fixed_block_pool_allocator.sv @@
// Allocate, zeroed allocate, null free and reset pool: the word is accepted in IDLE, the link
// memory read is registered, then DECIDE registers the result word (and the new head) once
// the output is free; no new word is accepted until IDLE. A free that needs a slot number also
// passes DIV and FREE; in DIV the one-bit-per-cycle divider turns the byte offset into a slot number.
// After rst_ni, after each register write and after a reset pool operation the link memory
// is rebuilt over all MAX_BLOCKS entries, one entry per cycle, while no word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS   = fbpa_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned OFFSET_WIDTH = fbpa_pkg::DEF_OFFSET_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [fbpa_pkg::CFG_INDEX_W-1:0]       cfg_index_i,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]        cfg_data_i,

  input  wire logic                                   s_tvalid_i,
  output logic                                        s_tready_o,
  // request_bytes, element_count, block_offset, offset_is_null, zero padding
  input  wire logic [((fbpa_pkg::REQ_W + fbpa_pkg::ELEM_W + OFFSET_WIDTH + 1 + 7) / 8) * 8 - 1:0]
                                                      s_tdata_i,
  // operation
  input  wire logic [fbpa_pkg::OP_W-1:0]              s_tuser_i,

  output logic                                        m_tvalid_o,
  input  wire logic                                   m_tready_i,
  // granted_offset, zero_fill, used_count, free_count, zero padding
  output logic [((OFFSET_WIDTH + 1 + 2 * fbpa_pkg::COUNT_W + 7) / 8) * 8 - 1:0]
                                                      m_tdata_o,
  // status
  output logic [fbpa_pkg::STATUS_W-1:0]               m_tuser_o
);

  localparam int unsigned OW         = OFFSET_WIDTH;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = fbpa_pkg::COUNT_W;
  localparam int unsigned BYTES_W    = fbpa_pkg::BYTES_W;
  localparam int unsigned SIZE_W     = fbpa_pkg::SIZE_W;
  localparam int unsigned REQ_W      = fbpa_pkg::REQ_W;
  localparam int unsigned ELEM_W     = fbpa_pkg::ELEM_W;
  localparam int unsigned TOT_W      = CNT_W + BYTES_W;
  localparam int unsigned GP_W       = IDX_W + BYTES_W;
  localparam int unsigned OC_W       = (OW > TOT_W) ? OW : TOT_W;
  localparam int unsigned CMP_W      = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int unsigned OUT_DATA_W = ((OW + 1 + 2 * CNT_W + 7) / 8) * 8;
  localparam int unsigned N_RESET    = (fbpa_pkg::DEF_BLOCKS_IN_USE > MAX_BLOCKS) ?
                                       MAX_BLOCKS : fbpa_pkg::DEF_BLOCKS_IN_USE;

  fbpa_pkg::fbpa_state_e state_q, state_d;

  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [IDX_W-1:0]   sweep_q, sweep_d;

  fbpa_pkg::fbpa_op_e op_q;
  logic [OW-1:0]      off_q;
  logic               null_q;
  logic [SIZE_W-1:0]  size_q;
  logic [TOT_W-1:0]   total_q;
  logic [OW-1:0]      grant_q;

  logic                   m_valid_q, m_valid_d;
  fbpa_pkg::fbpa_status_e m_status_q, m_status_d;
  logic [OW-1:0]          m_grant_q, m_grant_d;
  logic                   m_zero_q, m_zero_d;
  logic [CNT_W-1:0]       m_used_q, m_used_d;
  logic [CNT_W-1:0]       m_free_q, m_free_d;

  logic [REQ_W-1:0]  in_req;
  logic [ELEM_W-1:0] in_cnt;
  logic [OW-1:0]     in_off;
  logic              in_null;

  logic accept, out_free, cfg_rebuild, sweep_last, free_in_range;
  fbpa_pkg::fbpa_status_e alloc_status;

  logic [CMP_W-1:0] sweep_next;
  logic [IDX_W-1:0] sweep_link;

  logic [17:0]      eff_bytes;
  logic [CNT_W-1:0] eff_count;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_wdata, ram_rdata;

  logic             div_start, div_done, div_exact;
  logic [IDX_W-1:0] div_quo;

  assign in_req  = s_tdata_i[REQ_W-1:0];
  assign in_cnt  = s_tdata_i[REQ_W +: ELEM_W];
  assign in_off  = s_tdata_i[REQ_W + ELEM_W +: OW];
  assign in_null = s_tdata_i[REQ_W + ELEM_W + OW];

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = (state_q == fbpa_pkg::ST_IDLE);
  assign accept      = s_tvalid_i && s_tready_o;
  assign out_free    = !m_valid_q || m_tready_i;
  assign cfg_rebuild = cfg_valid_i && ((cfg_index_i == fbpa_pkg::CFG_BLOCK_BYTES) ||
                                       (cfg_index_i == fbpa_pkg::CFG_BLOCKS_IN_USE));
  assign sweep_last  = (sweep_q == IDX_W'(MAX_BLOCKS - 1));
  assign sweep_next  = CMP_W'(sweep_q) + 1'b1;
  assign sweep_link  = (sweep_next < CMP_W'(n_q)) ? IDX_W'(sweep_next) : '0;
  assign free_in_range = OC_W'(off_q) < OC_W'(total_q);

  // Register values are brought into range when they are written.
  always_comb begin
    eff_bytes = 18'(cfg_data_i);
    if (eff_bytes < 18'(fbpa_pkg::ALIGN_BYTES)) begin
      eff_bytes = 18'(fbpa_pkg::ALIGN_BYTES);
    end
    eff_bytes = (eff_bytes + 18'(fbpa_pkg::ALIGN_BYTES - 1)) &
                ~18'(fbpa_pkg::ALIGN_BYTES - 1);
    if (eff_bytes > 18'(fbpa_pkg::MAX_BLOCK_BYTES)) begin
      eff_bytes = 18'(fbpa_pkg::MAX_BLOCK_BYTES);
    end
    eff_count = cfg_data_i[CNT_W-1:0];
    if (eff_count == '0) begin
      eff_count = CNT_W'(1);
    end
    if (32'(eff_count) > 32'(MAX_BLOCKS)) begin
      eff_count = CNT_W'(MAX_BLOCKS);
    end
  end

  always_comb begin
    if (size_q == '0) begin
      alloc_status = fbpa_pkg::STAT_ZERO_SIZE;
    end else if (size_q > SIZE_W'(bytes_q)) begin
      alloc_status = fbpa_pkg::STAT_TOO_LARGE;
    end else if (used_q >= n_q) begin
      alloc_status = fbpa_pkg::STAT_POOL_EMPTY;
    end else begin
      alloc_status = fbpa_pkg::STAT_OK;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbpa_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_d = fbpa_pkg::ST_IDLE;
        end
      end
      fbpa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = fbpa_pkg::ST_DECIDE;
        end
      end
      fbpa_pkg::ST_DECIDE: begin
        unique case (op_q)
          fbpa_pkg::OP_ALLOC, fbpa_pkg::OP_ZALLOC: begin
            if (out_free) begin
              state_d = fbpa_pkg::ST_IDLE;
            end
          end
          fbpa_pkg::OP_FREE: begin
            if (!null_q && free_in_range) begin
              state_d = fbpa_pkg::ST_DIV;
            end else if (out_free) begin
              state_d = fbpa_pkg::ST_IDLE;
            end
          end
          fbpa_pkg::OP_RESET: begin
            if (out_free) begin
              state_d = fbpa_pkg::ST_SWEEP;
            end
          end
        endcase
      end
      fbpa_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = fbpa_pkg::ST_FREE;
        end
      end
      fbpa_pkg::ST_FREE: begin
        if (out_free) begin
          state_d = fbpa_pkg::ST_IDLE;
        end
      end
      default: state_d = fbpa_pkg::ST_SWEEP;
    endcase
    if (cfg_rebuild) begin
      state_d = fbpa_pkg::ST_SWEEP;
    end
  end

  // Datapath, memory and result word.
  always_comb begin
    bytes_d    = bytes_q;
    n_d        = n_q;
    head_d     = head_q;
    used_d     = used_q;
    sweep_d    = sweep_q;
    ram_we     = 1'b0;
    ram_waddr  = sweep_q;
    ram_wdata  = sweep_link;
    ram_re     = accept;
    div_start  = 1'b0;
    m_valid_d  = m_valid_q && !m_tready_i;
    m_status_d = m_status_q;
    m_grant_d  = m_grant_q;
    m_zero_d   = m_zero_q;
    m_used_d   = m_used_q;
    m_free_d   = m_free_q;

    unique case (state_q)
      fbpa_pkg::ST_SWEEP: begin
        ram_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
      end
      fbpa_pkg::ST_IDLE: begin
      end
      fbpa_pkg::ST_DECIDE: begin
        unique case (op_q)
          fbpa_pkg::OP_ALLOC, fbpa_pkg::OP_ZALLOC: begin
            if (out_free) begin
              m_valid_d  = 1'b1;
              m_status_d = alloc_status;
              m_grant_d  = '0;
              m_zero_d   = 1'b0;
              if (alloc_status == fbpa_pkg::STAT_OK) begin
                head_d    = ram_rdata;
                used_d    = used_q + 1'b1;
                m_grant_d = grant_q;
                m_zero_d  = (op_q == fbpa_pkg::OP_ZALLOC);
              end
              m_used_d = used_d;
              m_free_d = n_q - used_d;
            end
          end
          fbpa_pkg::OP_FREE: begin
            if (!null_q && free_in_range) begin
              div_start = 1'b1;
            end else if (out_free) begin
              m_valid_d  = 1'b1;
              m_status_d = null_q ? fbpa_pkg::STAT_OK : fbpa_pkg::STAT_BAD_FREE;
              m_grant_d  = '0;
              m_zero_d   = 1'b0;
              m_used_d   = used_q;
              m_free_d   = n_q - used_q;
            end
          end
          fbpa_pkg::OP_RESET: begin
            if (out_free) begin
              head_d     = '0;
              used_d     = '0;
              sweep_d    = '0;
              m_valid_d  = 1'b1;
              m_status_d = fbpa_pkg::STAT_OK;
              m_grant_d  = '0;
              m_zero_d   = 1'b0;
              m_used_d   = '0;
              m_free_d   = n_q;
            end
          end
        endcase
      end
      fbpa_pkg::ST_DIV: begin
      end
      fbpa_pkg::ST_FREE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_grant_d = '0;
          m_zero_d  = 1'b0;
          if (!div_exact) begin
            m_status_d = fbpa_pkg::STAT_BAD_FREE;
          end else if (used_q == '0) begin
            m_status_d = fbpa_pkg::STAT_NONE_IN_USE;
          end else begin
            // Push the freed slot: it links to the old head and becomes the head.
            m_status_d = fbpa_pkg::STAT_OK;
            ram_we     = 1'b1;
            ram_waddr  = div_quo;
            ram_wdata  = head_q;
            head_d     = div_quo;
            used_d     = used_q - 1'b1;
          end
          m_used_d = used_d;
          m_free_d = n_q - used_d;
        end
      end
      default: begin
      end
    endcase

    if (cfg_valid_i) begin
      if (cfg_index_i == fbpa_pkg::CFG_BLOCK_BYTES) begin
        bytes_d = BYTES_W'(eff_bytes);
      end
      if (cfg_index_i == fbpa_pkg::CFG_BLOCKS_IN_USE) begin
        n_d = eff_count;
      end
      if (cfg_rebuild) begin
        head_d  = '0;
        used_d  = '0;
        sweep_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fbpa_pkg::ST_SWEEP;
      bytes_q   <= BYTES_W'(fbpa_pkg::DEF_BLOCK_BYTES);
      n_q       <= CNT_W'(N_RESET);
      head_q    <= '0;
      used_q    <= '0;
      sweep_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bytes_q   <= bytes_d;
      n_q       <= n_d;
      head_q    <= head_d;
      used_q    <= used_d;
      sweep_q   <= sweep_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Size, pool total and granted offset are registered when a word is accepted.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= fbpa_pkg::fbpa_op_e'(s_tuser_i);
      off_q   <= in_off;
      null_q  <= in_null;
      size_q  <= (fbpa_pkg::fbpa_op_e'(s_tuser_i) == fbpa_pkg::OP_ZALLOC) ?
                 SIZE_W'(in_req) * SIZE_W'(in_cnt) : SIZE_W'(in_req);
      total_q <= TOT_W'(n_q) * TOT_W'(bytes_q);
      grant_q <= OW'(GP_W'(head_q) * GP_W'(bytes_q));
    end
    m_status_q <= m_status_d;
    m_grant_q  <= m_grant_d;
    m_zero_q   <= m_zero_d;
    m_used_q   <= m_used_d;
    m_free_q   <= m_free_d;
  end

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  fbpa_div #(
    .DVD_W (OW),
    .DVS_W (BYTES_W),
    .QUO_W (IDX_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_q),
    .divisor_i  (bytes_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .exact_o    (div_exact)
  );

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = OUT_DATA_W'({m_free_q, m_used_q, m_zero_q, m_grant_q});
  assign m_tuser_o  = m_status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= n_q)
    else $error("used count exceeds the pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fbpa_pkg::ST_IDLE) |-> (CMP_W'(head_q) < CMP_W'(n_q)))
    else $error("free list head points outside the pool");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fbpa_pkg::ST_SWEEP) |-> (used_q == '0 && head_q == '0))
    else $error("pool state not cleared during link rebuild");

endmodule

`default_nettype wire

@@ hdl/fbpa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/fbpa_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor << QUO_W, which the range check ahead of it guarantees.
module fbpa_div #(
  parameter int unsigned DVD_W = 26,
  parameter int unsigned DVS_W = 17,
  parameter int unsigned QUO_W = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [QUO_W-1:0] quotient_o,
  output logic                  exact_o
);

  localparam int unsigned DS_W   = DVS_W + QUO_W;
  localparam int unsigned CW     = (DVD_W > DS_W) ? DVD_W : DS_W;
  localparam int unsigned STEP_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  rem_q, rem_d;
  logic [DS_W-1:0]   dsr_q, dsr_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic              fits;

  assign fits = CW'(rem_q) >= CW'(dsr_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(QUO_W - 1);
      rem_d  = dividend_i;
      dsr_d  = DS_W'(divisor_i) << (QUO_W - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DVD_W'(CW'(rem_q) - CW'(dsr_q));
      end
      quo_d = (quo_q << 1) | QUO_W'(fits);
      dsr_d = dsr_q >> 1;
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign exact_o    = (rem_q == '0);

endmodule

`default_nettype wire
